>>> design/spq_pkg.sv
package spq_pkg;

  // Operation codes carried on in_operation.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SCAN,
    S_INS,
    S_FIN
  } spq_state_t;

endpackage

>>> design/spq_ram.sv
module spq_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/sorted_priority_queue.sv
// A pop on an empty queue, a push on a full one and a push into an empty one go
// straight to S_FIN; a pop reads the head, takes it in S_POP and then goes to
// S_FIN; a push into a non-empty queue scans in S_SCAN, moving each larger stored
// entry one slot back, passes S_INS if every entry was larger, and ends in S_FIN.
// Input is taken only in S_IDLE, after S_FIN registers the result; the single
// read port of the entry memory sets the insertion scan at one entry per cycle.
// Synchronous active-low reset empties the queue; memory contents are not cleared.
module sorted_priority_queue #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 48,
  parameter int TAG_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  // Input channel.
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_operation,
  input  logic [KEY_BITS-1:0] in_key,
  input  logic [TAG_BITS-1:0] in_tag,
  // Result channel.
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_pop_valid,
  output logic [KEY_BITS-1:0] out_key,
  output logic [TAG_BITS-1:0] out_tag,
  output logic                out_now_empty,
  output logic [1:0]          out_status
);

  // The queue lives in one memory as a circular buffer. Slot head_r holds the
  // smallest key, and the entry at offset i from the head is the i-th in order.
  // A pop reads the head and advances the pointer. A push walks from the tail
  // toward the head, one read per cycle, moving every larger key one slot back,
  // and drops the new item into the gap. The read of offset i-1 and the write to
  // offset i+1 never touch the same entry, so no forwarding is needed.
  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AW1 = AW + 1;
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int EW  = KEY_BITS + TAG_BITS;
  localparam logic [AW:0]   DEPTH_W = AW1'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // Adds an offset to a slot index modulo DEPTH. Both operands are below DEPTH,
  // so one conditional subtract is enough.
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                             input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[AW-1:0];
  endfunction

  spq_pkg::spq_state_t state_r, state_nxt;

  logic [AW-1:0]       head_r, head_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic [KEY_BITS-1:0] nkey_r, nkey_nxt;
  logic [TAG_BITS-1:0] ntag_r, ntag_nxt;

  // Result of the item in flight, waiting for the output register.
  logic                res_valid_r, res_valid_nxt;
  logic [KEY_BITS-1:0] res_key_r, res_key_nxt;
  logic [TAG_BITS-1:0] res_tag_r, res_tag_nxt;
  logic [1:0]          res_status_r, res_status_nxt;

  // Output register; a result waits here while the core takes the next item.
  logic                out_valid_r, out_valid_nxt;
  logic                out_pop_valid_r, out_pop_valid_nxt;
  logic [KEY_BITS-1:0] out_key_r, out_key_nxt;
  logic [TAG_BITS-1:0] out_tag_r, out_tag_nxt;
  logic                out_now_empty_r, out_now_empty_nxt;
  logic [1:0]          out_status_r, out_status_nxt;

  // Entry memory port signals.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  logic [KEY_BITS-1:0] rd_key;
  logic [TAG_BITS-1:0] rd_tag;
  logic                rd_gt;
  logic                q_empty;
  logic                q_full;
  logic                fin_go;
  logic [AW-1:0]       last_off;

  assign rd_key   = ram_rdata[EW-1:TAG_BITS];
  assign rd_tag   = ram_rdata[TAG_BITS-1:0];
  // A stored key equal to the new one stops the scan, which keeps equal keys
  // in arrival order.
  assign rd_gt    = rd_key > nkey_r;
  assign q_empty  = (cnt_r == '0);
  assign q_full   = (cnt_r == DEPTH_C);
  // The output register is free, or its result leaves in this cycle.
  assign fin_go   = !out_valid_r || !out_stall;
  // Offset of the tail entry; only used when the queue is neither empty nor
  // full, so the count fits the offset width.
  assign last_off = AW'(cnt_r - CW'(1));

  assign in_stall = (state_r != spq_pkg::S_IDLE);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spq_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_operation == spq_pkg::OP_POP) begin
            state_nxt = q_empty ? spq_pkg::S_FIN : spq_pkg::S_POP;
          end else begin
            state_nxt = (q_empty || q_full) ? spq_pkg::S_FIN : spq_pkg::S_SCAN;
          end
        end
      end
      spq_pkg::S_POP: begin
        state_nxt = spq_pkg::S_FIN;
      end
      spq_pkg::S_SCAN: begin
        if (rd_gt) begin
          state_nxt = (idx_r == '0) ? spq_pkg::S_INS : spq_pkg::S_SCAN;
        end else begin
          state_nxt = spq_pkg::S_FIN;
        end
      end
      spq_pkg::S_INS: begin
        state_nxt = spq_pkg::S_FIN;
      end
      spq_pkg::S_FIN: begin
        if (fin_go) begin
          state_nxt = spq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = spq_pkg::S_IDLE;
      end
    endcase
  end

  // Memory accesses and register updates.
  always_comb begin
    head_nxt       = head_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    nkey_nxt       = nkey_r;
    ntag_nxt       = ntag_r;
    res_valid_nxt  = res_valid_r;
    res_key_nxt    = res_key_r;
    res_tag_nxt    = res_tag_r;
    res_status_nxt = res_status_r;

    out_valid_nxt     = out_valid_r && out_stall;
    out_pop_valid_nxt = out_pop_valid_r;
    out_key_nxt       = out_key_r;
    out_tag_nxt       = out_tag_r;
    out_now_empty_nxt = out_now_empty_r;
    out_status_nxt    = out_status_r;

    ram_we    = 1'b0;
    ram_waddr = head_r;
    ram_wdata = {nkey_r, ntag_r};
    ram_raddr = head_r;

    case (state_r)
      spq_pkg::S_IDLE: begin
        if (in_valid) begin
          nkey_nxt       = in_key;
          ntag_nxt       = in_tag;
          res_valid_nxt  = 1'b0;
          res_key_nxt    = '0;
          res_tag_nxt    = '0;
          res_status_nxt = spq_pkg::ST_OK;
          if (in_operation == spq_pkg::OP_POP) begin
            if (q_empty) begin
              res_status_nxt = spq_pkg::ST_EMPTY;
            end
            // Otherwise the head is read here and returns in S_POP.
          end else if (q_full) begin
            res_status_nxt = spq_pkg::ST_FULL;
          end else if (q_empty) begin
            ram_we    = 1'b1;
            ram_waddr = head_r;
            ram_wdata = {in_key, in_tag};
            cnt_nxt   = cnt_r + CW'(1);
          end else begin
            ram_raddr = wrap_add(head_r, last_off);
            idx_nxt   = last_off;
          end
        end
      end
      spq_pkg::S_POP: begin
        res_valid_nxt = 1'b1;
        res_key_nxt   = rd_key;
        res_tag_nxt   = rd_tag;
        head_nxt      = wrap_add(head_r, AW'(1));
        cnt_nxt       = cnt_r - CW'(1);
      end
      spq_pkg::S_SCAN: begin
        ram_we    = 1'b1;
        ram_waddr = wrap_add(head_r, idx_r + AW'(1));
        if (rd_gt) begin
          // Move the larger entry back one slot and look one slot further up.
          ram_wdata = ram_rdata;
          if (idx_r != '0) begin
            idx_nxt   = idx_r - AW'(1);
            ram_raddr = wrap_add(head_r, idx_r - AW'(1));
          end
        end else begin
          ram_wdata = {nkey_r, ntag_r};
          cnt_nxt   = cnt_r + CW'(1);
        end
      end
      spq_pkg::S_INS: begin
        // Every stored key was larger: the new item becomes the head.
        ram_we    = 1'b1;
        ram_waddr = head_r;
        ram_wdata = {nkey_r, ntag_r};
        cnt_nxt   = cnt_r + CW'(1);
      end
      spq_pkg::S_FIN: begin
        if (fin_go) begin
          out_valid_nxt     = 1'b1;
          out_pop_valid_nxt = res_valid_r;
          out_key_nxt       = res_key_r;
          out_tag_nxt       = res_tag_r;
          out_now_empty_nxt = q_empty;
          out_status_nxt    = res_status_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spq_pkg::S_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    idx_r           <= idx_nxt;
    nkey_r          <= nkey_nxt;
    ntag_r          <= ntag_nxt;
    res_valid_r     <= res_valid_nxt;
    res_key_r       <= res_key_nxt;
    res_tag_r       <= res_tag_nxt;
    res_status_r    <= res_status_nxt;
    out_pop_valid_r <= out_pop_valid_nxt;
    out_key_r       <= out_key_nxt;
    out_tag_r       <= out_tag_nxt;
    out_now_empty_r <= out_now_empty_nxt;
    out_status_r    <= out_status_nxt;
  end

  spq_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_valid     = out_valid_r;
  assign out_pop_valid = out_pop_valid_r;
  assign out_key       = out_key_r;
  assign out_tag       = out_tag_r;
  assign out_now_empty = out_now_empty_r;
  assign out_status    = out_status_r;

endmodule

>>> design/spq_checker.sv
module spq_checker #(
  parameter int KEY_BITS = 48,
  parameter int TAG_BITS = 32
) (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input logic                out_pop_valid,
  input logic [KEY_BITS-1:0] out_key,
  input logic [TAG_BITS-1:0] out_tag,
  input logic                out_now_empty,
  input logic [1:0]          out_status
);

  // A returned entry always comes with an ok status.
  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pop_valid |-> out_status == spq_pkg::ST_OK)
    else $error("popped entry with non-ok status");

  // Results that return no entry carry zero key and tag.
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pop_valid |-> out_key == '0 && out_tag == '0)
    else $error("nonzero payload without a popped entry");

  // A pop that found nothing leaves the queue empty; a dropped push leaves it non-empty.
  a_status_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == spq_pkg::ST_EMPTY |-> out_now_empty)
    else $error("empty-pop status with non-empty queue");

  a_status_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == spq_pkg::ST_FULL |-> !out_now_empty)
    else $error("full-push status with empty queue");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_key) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind sorted_priority_queue spq_checker #(
  .KEY_BITS(KEY_BITS),
  .TAG_BITS(TAG_BITS)
) u_spq_checker (.*);
